@@ design/cti_pkg.sv @@
// ----------------------------------------------------------------------------
// cti_pkg - transfer instruction unit shared definitions
// Beat payload types, register file state, opcode and access codes.
// ----------------------------------------------------------------------------
package cti_pkg;

   // access kinds carried on a result beat
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_RETIRE = 2'd2;

   // outstanding read tracking
   localparam logic [1:0] STAGE_IDLE   = 2'd0;
   localparam logic [1:0] STAGE_FIRST  = 2'd1;
   localparam logic [1:0] STAGE_SECOND = 2'd2;

   localparam logic [15:0] HIGH_PAGE  = 16'hFF00;
   localparam logic [7:0]  FLAGS_MASK = 8'hF0;

   // register index taken from opcode fields; 6 selects memory at HL
   localparam logic [2:0] REG_IDX_B   = 3'd0;
   localparam logic [2:0] REG_IDX_C   = 3'd1;
   localparam logic [2:0] REG_IDX_D   = 3'd2;
   localparam logic [2:0] REG_IDX_E   = 3'd3;
   localparam logic [2:0] REG_IDX_H   = 3'd4;
   localparam logic [2:0] REG_IDX_L   = 3'd5;
   localparam logic [2:0] REG_IDX_MEM = 3'd6;
   localparam logic [2:0] REG_IDX_A   = 3'd7;

   // register pair index from opcode bits 5:4 for push and pop
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_AF = 2'd3;

   localparam logic [7:0] OP_HALT       = 8'h76;
   localparam logic [7:0] OP_LD_BC_D16  = 8'h01;
   localparam logic [7:0] OP_LD_DE_D16  = 8'h11;
   localparam logic [7:0] OP_LD_HL_D16  = 8'h21;
   localparam logic [7:0] OP_LD_SP_D16  = 8'h31;
   localparam logic [7:0] OP_LD_B_D8    = 8'h06;
   localparam logic [7:0] OP_LD_C_D8    = 8'h0E;
   localparam logic [7:0] OP_LD_D_D8    = 8'h16;
   localparam logic [7:0] OP_LD_E_D8    = 8'h1E;
   localparam logic [7:0] OP_LD_H_D8    = 8'h26;
   localparam logic [7:0] OP_LD_L_D8    = 8'h2E;
   localparam logic [7:0] OP_LD_A_D8    = 8'h3E;
   localparam logic [7:0] OP_LD_SP_HL   = 8'hF9;
   localparam logic [7:0] OP_LD_HL_SPR8 = 8'hF8;
   localparam logic [7:0] OP_LD_A_BC    = 8'h0A;
   localparam logic [7:0] OP_LD_A_DE    = 8'h1A;
   localparam logic [7:0] OP_LD_A_HLI   = 8'h2A;
   localparam logic [7:0] OP_LD_A_HLD   = 8'h3A;
   localparam logic [7:0] OP_LDH_A_C    = 8'hF2;
   localparam logic [7:0] OP_LDH_A_A8   = 8'hF0;
   localparam logic [7:0] OP_LD_A_A16   = 8'hFA;
   localparam logic [7:0] OP_POP_BC     = 8'hC1;
   localparam logic [7:0] OP_POP_DE     = 8'hD1;
   localparam logic [7:0] OP_POP_HL     = 8'hE1;
   localparam logic [7:0] OP_POP_AF     = 8'hF1;
   localparam logic [7:0] OP_LD_BC_A    = 8'h02;
   localparam logic [7:0] OP_LD_DE_A    = 8'h12;
   localparam logic [7:0] OP_LD_HLI_A   = 8'h22;
   localparam logic [7:0] OP_LD_HLD_A   = 8'h32;
   localparam logic [7:0] OP_LD_HL_D8   = 8'h36;
   localparam logic [7:0] OP_LDH_C_A    = 8'hE2;
   localparam logic [7:0] OP_LDH_A8_A   = 8'hE0;
   localparam logic [7:0] OP_LD_A16_A   = 8'hEA;
   localparam logic [7:0] OP_LD_A16_SP  = 8'h08;
   localparam logic [7:0] OP_PUSH_BC    = 8'hC5;
   localparam logic [7:0] OP_PUSH_DE    = 8'hD5;
   localparam logic [7:0] OP_PUSH_HL    = 8'hE5;
   localparam logic [7:0] OP_PUSH_AF    = 8'hF5;
   localparam logic [7:0] OP_POP_MASK   = 8'hCF;
   localparam logic [7:0] OP_POP_BASE   = 8'hC1;

   // response queue
   localparam int RSP_Q_DEPTH = 4;

   typedef struct packed {
      logic        is_reply;
      logic [7:0]  opcode;
      logic [15:0] immediate_value;
      logic [7:0]  reply_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  access_kind;
      logic [15:0] mem_address;
      logic [7:0]  write_byte;
      logic [4:0]  cycle_count;
      logic        bad_opcode;
      logic [15:0] pair_af;
      logic [15:0] pair_bc;
      logic [15:0] pair_de;
      logic [15:0] pair_hl;
      logic [15:0] stack_pointer;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  a;
      logic [7:0]  f;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [15:0] sp;
      logic [1:0]  pending_stage;
      logic [7:0]  pending_opcode;
      logic [7:0]  popped_low;
   } state_type;

   // execute result: beats to queue and the updated register file
   typedef struct packed {
      logic [1:0]       count;
      rsp_type [2:0]    rsp;
      state_type        next;
   } exec_out_type;

endpackage

@@ design/cpu_transfer_instruction_unit.sv @@
// ----------------------------------------------------------------------------
// cpu_transfer_instruction_unit - 8-bit CPU transfer group executor
// Request register, single pass execute against the register file, and a
// four-beat response queue.
// ----------------------------------------------------------------------------
// A request beat is held in an input register and executed once the response
// queue has room for all the beats it causes; the register file updates in
// the same clock as the execute. Request beats can be taken every clock while
// the queue has room for the beats they cause. Each instruction gives one to
// three response beats (read request, writes, retire), and the response
// channel moves one beat per clock while rsp_ready is high, so the sustained
// rate is set by the response port. A memory read ends the beat with a read
// request; the instruction finishes on the following reply beat (two replies
// for a pop). Instruction beats that arrive while a read is outstanding, and
// replies with none outstanding, are consumed and give no response.
// ----------------------------------------------------------------------------
module cpu_transfer_instruction_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cti_pkg::rsp_type rsp_data
);

   cti_pkg::req_type      req_item_ff;
   logic                  req_valid_ff;
   logic                  req_valid_in;
   cti_pkg::state_type    state_ff;
   cti_pkg::state_type    state_in;
   cti_pkg::exec_out_type exec_out;
   logic [2:0]            q_count;
   logic                  fire;
   logic                  req_take;
   logic [1:0]            push_cnt;

   cti_exec u_exec (
      .item      (req_item_ff),
      .cur_state (state_ff),
      .result    (exec_out)
   );

   // execute only when every beat of this instruction fits in the queue
   assign fire         = req_valid_ff &&
                         (({1'b0, q_count} + {2'b00, exec_out.count}) <=
                          4'(cti_pkg::RSP_Q_DEPTH));
   assign req_ready    = !req_valid_ff || fire;
   assign req_take     = req_valid && req_ready;
   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign state_in     = fire ? exec_out.next : state_ff;
   assign push_cnt     = fire ? exec_out.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_data;
      end
   end

   cti_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_data  (exec_out.rsp),
      .pop        (rsp_valid && rsp_ready),
      .count      (q_count),
      .head_valid (rsp_valid),
      .head_data  (rsp_data)
   );

endmodule

@@ design/cti_exec.sv @@
// ----------------------------------------------------------------------------
// cti_exec - transfer group execute logic
// Decodes one request beat against the register file and produces the
// updated state and up to three response beats, all in one pass.
// ----------------------------------------------------------------------------
module cti_exec (
   input  cti_pkg::req_type      item,
   input  cti_pkg::state_type    cur_state,
   output cti_pkg::exec_out_type result
);

   cti_pkg::state_type nxt;
   cti_pkg::rsp_type   ret_beat;
   logic               rd_req;
   logic [15:0]        rd_addr;
   logic [1:0]         acc_cnt;
   logic [15:0]        acc0_addr;
   logic [7:0]         acc0_data;
   logic [15:0]        acc1_addr;
   logic [7:0]         acc1_data;
   logic               do_ret;
   logic [4:0]         ret_cyc;
   logic               ret_bad;
   logic [15:0]        hl;
   logic [15:0]        bc;
   logic [15:0]        de;
   logic [7:0]         lo;
   logic [15:0]        sext;
   logic [15:0]        spr8;
   logic [15:0]        spr8_x;

   function automatic logic [7:0] get_reg(cti_pkg::state_type s, logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         cti_pkg::REG_IDX_B: v = s.b;
         cti_pkg::REG_IDX_C: v = s.c;
         cti_pkg::REG_IDX_D: v = s.d;
         cti_pkg::REG_IDX_E: v = s.e;
         cti_pkg::REG_IDX_H: v = s.h;
         cti_pkg::REG_IDX_L: v = s.l;
         cti_pkg::REG_IDX_A: v = s.a;
         default:            v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic cti_pkg::state_type put_reg(cti_pkg::state_type s, logic [2:0] idx,
                                                  logic [7:0] v);
      cti_pkg::state_type r;
      r = s;
      case (idx)
         cti_pkg::REG_IDX_B: r.b = v;
         cti_pkg::REG_IDX_C: r.c = v;
         cti_pkg::REG_IDX_D: r.d = v;
         cti_pkg::REG_IDX_E: r.e = v;
         cti_pkg::REG_IDX_H: r.h = v;
         cti_pkg::REG_IDX_L: r.l = v;
         cti_pkg::REG_IDX_A: r.a = v;
         default:            r = s;
      endcase
      return r;
   endfunction

   function automatic cti_pkg::rsp_type mk_access(logic [1:0] kind, logic [15:0] addr,
                                                  logic [7:0] data, logic fin);
      cti_pkg::rsp_type r;
      r             = '0;
      r.access_kind = kind;
      r.mem_address = addr;
      r.write_byte  = data;
      r.last        = fin;
      return r;
   endfunction

   assign hl     = {cur_state.h, cur_state.l};
   assign bc     = {cur_state.b, cur_state.c};
   assign de     = {cur_state.d, cur_state.e};
   assign lo     = item.immediate_value[7:0];
   assign sext   = {{8{lo[7]}}, lo};
   assign spr8   = cur_state.sp + sext;
   assign spr8_x = cur_state.sp ^ sext ^ spr8;

   always_comb begin
      nxt       = cur_state;
      rd_req    = 1'b0;
      rd_addr   = '0;
      acc_cnt   = 2'd0;
      acc0_addr = '0;
      acc0_data = '0;
      acc1_addr = '0;
      acc1_data = '0;
      do_ret    = 1'b0;
      ret_cyc   = 5'd0;
      ret_bad   = 1'b0;
      if (cur_state.pending_stage != cti_pkg::STAGE_IDLE) begin
         // instruction beats are dropped while a read is outstanding
         if (item.is_reply) begin
            if ((cur_state.pending_opcode & cti_pkg::OP_POP_MASK) == cti_pkg::OP_POP_BASE) begin
               nxt.sp = cur_state.sp + 16'd1;
               if (cur_state.pending_stage == cti_pkg::STAGE_FIRST) begin
                  nxt.popped_low    = item.reply_data;
                  nxt.pending_stage = cti_pkg::STAGE_SECOND;
                  rd_req            = 1'b1;
                  rd_addr           = nxt.sp;
               end else begin
                  case (cur_state.pending_opcode[5:4])
                     cti_pkg::PAIR_BC: begin
                        nxt.b = item.reply_data;
                        nxt.c = cur_state.popped_low;
                     end
                     cti_pkg::PAIR_DE: begin
                        nxt.d = item.reply_data;
                        nxt.e = cur_state.popped_low;
                     end
                     cti_pkg::PAIR_HL: begin
                        nxt.h = item.reply_data;
                        nxt.l = cur_state.popped_low;
                     end
                     default: begin
                        nxt.a = item.reply_data;
                        nxt.f = cur_state.popped_low & cti_pkg::FLAGS_MASK;
                     end
                  endcase
                  nxt.pending_stage = cti_pkg::STAGE_IDLE;
                  do_ret            = 1'b1;
                  ret_cyc           = 5'd12;
               end
            end else begin
               if (cur_state.pending_opcode[7:6] == 2'b01) begin
                  nxt = put_reg(cur_state, cur_state.pending_opcode[5:3], item.reply_data);
               end else begin
                  nxt.a = item.reply_data;
               end
               if (cur_state.pending_opcode == cti_pkg::OP_LD_A_HLI) begin
                  {nxt.h, nxt.l} = hl + 16'd1;
               end
               if (cur_state.pending_opcode == cti_pkg::OP_LD_A_HLD) begin
                  {nxt.h, nxt.l} = hl - 16'd1;
               end
               if (cur_state.pending_opcode == cti_pkg::OP_LDH_A_A8) begin
                  ret_cyc = 5'd12;
               end else if (cur_state.pending_opcode == cti_pkg::OP_LD_A_A16) begin
                  ret_cyc = 5'd16;
               end else begin
                  ret_cyc = 5'd8;
               end
               nxt.pending_stage = cti_pkg::STAGE_IDLE;
               do_ret            = 1'b1;
            end
         end
      end else if (!item.is_reply) begin
         if (item.opcode[7:6] == 2'b01 && item.opcode != cti_pkg::OP_HALT) begin
            if (item.opcode[2:0] == cti_pkg::REG_IDX_MEM) begin
               rd_req  = 1'b1;
               rd_addr = hl;
            end else if (item.opcode[5:3] == cti_pkg::REG_IDX_MEM) begin
               acc_cnt   = 2'd1;
               acc0_addr = hl;
               acc0_data = get_reg(cur_state, item.opcode[2:0]);
               do_ret    = 1'b1;
               ret_cyc   = 5'd8;
            end else begin
               nxt     = put_reg(cur_state, item.opcode[5:3],
                                 get_reg(cur_state, item.opcode[2:0]));
               do_ret  = 1'b1;
               ret_cyc = 5'd4;
            end
         end else begin
            unique case (item.opcode) inside
               cti_pkg::OP_LD_BC_D16: begin
                  {nxt.b, nxt.c} = item.immediate_value;
                  do_ret = 1'b1;
                  ret_cyc = 5'd12;
               end
               cti_pkg::OP_LD_DE_D16: begin
                  {nxt.d, nxt.e} = item.immediate_value;
                  do_ret = 1'b1;
                  ret_cyc = 5'd12;
               end
               cti_pkg::OP_LD_HL_D16: begin
                  {nxt.h, nxt.l} = item.immediate_value;
                  do_ret = 1'b1;
                  ret_cyc = 5'd12;
               end
               cti_pkg::OP_LD_SP_D16: begin
                  nxt.sp  = item.immediate_value;
                  do_ret  = 1'b1;
                  ret_cyc = 5'd12;
               end
               // destination index sits in bits 5:3 as for register moves
               cti_pkg::OP_LD_B_D8, cti_pkg::OP_LD_C_D8, cti_pkg::OP_LD_D_D8,
               cti_pkg::OP_LD_E_D8, cti_pkg::OP_LD_H_D8, cti_pkg::OP_LD_L_D8,
               cti_pkg::OP_LD_A_D8: begin
                  nxt     = put_reg(cur_state, item.opcode[5:3], lo);
                  do_ret  = 1'b1;
                  ret_cyc = 5'd8;
               end
               cti_pkg::OP_LD_SP_HL: begin
                  nxt.sp  = hl;
                  do_ret  = 1'b1;
                  ret_cyc = 5'd8;
               end
               cti_pkg::OP_LD_HL_SPR8: begin
                  nxt.f          = {2'b00, spr8_x[4], spr8_x[8], 4'b0000};
                  {nxt.h, nxt.l} = spr8;
                  do_ret         = 1'b1;
                  ret_cyc        = 5'd12;
               end
               cti_pkg::OP_LD_A_BC: begin
                  rd_req  = 1'b1;
                  rd_addr = bc;
               end
               cti_pkg::OP_LD_A_DE: begin
                  rd_req  = 1'b1;
                  rd_addr = de;
               end
               cti_pkg::OP_LD_A_HLI, cti_pkg::OP_LD_A_HLD: begin
                  rd_req  = 1'b1;
                  rd_addr = hl;
               end
               cti_pkg::OP_LDH_A_C: begin
                  rd_req  = 1'b1;
                  rd_addr = cti_pkg::HIGH_PAGE + {8'h00, cur_state.c};
               end
               cti_pkg::OP_LDH_A_A8: begin
                  rd_req  = 1'b1;
                  rd_addr = cti_pkg::HIGH_PAGE + {8'h00, lo};
               end
               cti_pkg::OP_LD_A_A16: begin
                  rd_req  = 1'b1;
                  rd_addr = item.immediate_value;
               end
               cti_pkg::OP_POP_BC, cti_pkg::OP_POP_DE, cti_pkg::OP_POP_HL,
               cti_pkg::OP_POP_AF: begin
                  rd_req  = 1'b1;
                  rd_addr = cur_state.sp;
               end
               cti_pkg::OP_LD_BC_A: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = bc;
                  acc0_data = cur_state.a;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd8;
               end
               cti_pkg::OP_LD_DE_A: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = de;
                  acc0_data = cur_state.a;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd8;
               end
               cti_pkg::OP_LD_HLI_A: begin
                  acc_cnt        = 2'd1;
                  acc0_addr      = hl;
                  acc0_data      = cur_state.a;
                  {nxt.h, nxt.l} = hl + 16'd1;
                  do_ret         = 1'b1;
                  ret_cyc        = 5'd8;
               end
               cti_pkg::OP_LD_HLD_A: begin
                  acc_cnt        = 2'd1;
                  acc0_addr      = hl;
                  acc0_data      = cur_state.a;
                  {nxt.h, nxt.l} = hl - 16'd1;
                  do_ret         = 1'b1;
                  ret_cyc        = 5'd8;
               end
               cti_pkg::OP_LD_HL_D8: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = hl;
                  acc0_data = lo;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd12;
               end
               cti_pkg::OP_LDH_C_A: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = cti_pkg::HIGH_PAGE + {8'h00, cur_state.c};
                  acc0_data = cur_state.a;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd8;
               end
               cti_pkg::OP_LDH_A8_A: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = cti_pkg::HIGH_PAGE + {8'h00, lo};
                  acc0_data = cur_state.a;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd12;
               end
               cti_pkg::OP_LD_A16_A: begin
                  acc_cnt   = 2'd1;
                  acc0_addr = item.immediate_value;
                  acc0_data = cur_state.a;
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd16;
               end
               cti_pkg::OP_LD_A16_SP: begin
                  acc_cnt   = 2'd2;
                  acc0_addr = item.immediate_value;
                  acc0_data = cur_state.sp[7:0];
                  acc1_addr = item.immediate_value + 16'd1;
                  acc1_data = cur_state.sp[15:8];
                  do_ret    = 1'b1;
                  ret_cyc   = 5'd20;
               end
               cti_pkg::OP_PUSH_BC, cti_pkg::OP_PUSH_DE, cti_pkg::OP_PUSH_HL,
               cti_pkg::OP_PUSH_AF: begin
                  acc_cnt   = 2'd2;
                  acc0_addr = cur_state.sp - 16'd1;
                  acc1_addr = cur_state.sp - 16'd2;
                  case (item.opcode[5:4])
                     cti_pkg::PAIR_BC: begin
                        acc0_data = cur_state.b;
                        acc1_data = cur_state.c;
                     end
                     cti_pkg::PAIR_DE: begin
                        acc0_data = cur_state.d;
                        acc1_data = cur_state.e;
                     end
                     cti_pkg::PAIR_HL: begin
                        acc0_data = cur_state.h;
                        acc1_data = cur_state.l;
                     end
                     default: begin
                        acc0_data = cur_state.a;
                        acc1_data = cur_state.f & cti_pkg::FLAGS_MASK;
                     end
                  endcase
                  nxt.sp  = cur_state.sp - 16'd2;
                  do_ret  = 1'b1;
                  ret_cyc = 5'd16;
               end
               default: begin
                  do_ret  = 1'b1;
                  ret_bad = 1'b1;
               end
            endcase
         end
         if (rd_req) begin
            nxt.pending_stage  = cti_pkg::STAGE_FIRST;
            nxt.pending_opcode = item.opcode;
         end
      end
   end

   // retire beat reports the register file as left by this instruction
   always_comb begin
      ret_beat               = '0;
      ret_beat.access_kind   = cti_pkg::KIND_RETIRE;
      ret_beat.cycle_count   = ret_cyc;
      ret_beat.bad_opcode    = ret_bad;
      ret_beat.pair_af       = {nxt.a, nxt.f & cti_pkg::FLAGS_MASK};
      ret_beat.pair_bc       = {nxt.b, nxt.c};
      ret_beat.pair_de       = {nxt.d, nxt.e};
      ret_beat.pair_hl       = {nxt.h, nxt.l};
      ret_beat.stack_pointer = nxt.sp;
      ret_beat.last          = 1'b1;
   end

   always_comb begin
      result.next  = nxt;
      result.rsp   = '0;
      result.count = 2'd0;
      if (rd_req) begin
         result.rsp[0] = mk_access(cti_pkg::KIND_READ, rd_addr, 8'h00, 1'b1);
         result.count  = 2'd1;
      end else if (do_ret) begin
         case (acc_cnt)
            2'd0: begin
               result.rsp[0] = ret_beat;
               result.count  = 2'd1;
            end
            2'd1: begin
               result.rsp[0] = mk_access(cti_pkg::KIND_WRITE, acc0_addr, acc0_data, 1'b0);
               result.rsp[1] = ret_beat;
               result.count  = 2'd2;
            end
            default: begin
               result.rsp[0] = mk_access(cti_pkg::KIND_WRITE, acc0_addr, acc0_data, 1'b0);
               result.rsp[1] = mk_access(cti_pkg::KIND_WRITE, acc1_addr, acc1_data, 1'b0);
               result.rsp[2] = ret_beat;
               result.count  = 2'd3;
            end
         endcase
      end
   end

endmodule

@@ design/cti_rsp_queue.sv @@
// ----------------------------------------------------------------------------
// cti_rsp_queue - response beat queue
// Takes up to three beats per cycle from execute and hands them out one a
// cycle on the response channel, as the consumer pops them.
// ----------------------------------------------------------------------------
module cti_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_cnt,
   input  cti_pkg::rsp_type [2:0] push_data,
   input  logic                  pop,
   output logic [2:0]            count,
   output logic                  head_valid,
   output cti_pkg::rsp_type      head_data
);

   cti_pkg::rsp_type entry_ff [cti_pkg::RSP_Q_DEPTH];
   logic [1:0]       wr_ptr_ff;
   logic [1:0]       wr_ptr_in;
   logic [1:0]       rd_ptr_ff;
   logic [1:0]       rd_ptr_in;
   logic [2:0]       count_ff;
   logic [2:0]       count_in;

   assign wr_ptr_in = wr_ptr_ff + push_cnt;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, push_cnt} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < push_cnt) begin
            entry_ff[wr_ptr_ff + 2'(i)] <= push_data[i];
         end
      end
   end

   assign count      = count_ff;
   assign head_valid = (count_ff != 3'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

@@ bench/tb_cpu_transfer_instruction_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cpu_transfer_instruction_unit - transfer instruction unit testbench
// Drives instruction and read-reply beats, follows the register file in a
// local executor, and checks every response beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_cpu_transfer_instruction_unit;

   localparam int RANDOM_ITEMS = 141;
   localparam int PHASE_LEN    = 47;
   localparam int TAIL_CYCLES  = 16;
   localparam int CYCLE_LIMIT  = 200000;

   // opcodes outside the group used by the directed rows
   localparam logic [7:0] OP_NOP    = 8'h00;
   localparam logic [7:0] OP_RST_38 = 8'hFF;

   typedef struct {
      cti_pkg::req_type beat;
      bit               typed;
      cti_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   cti_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   cti_pkg::rsp_type rsp_data;

   cti_pkg::state_type cpu;
   cti_pkg::rsp_type   beats_due [$];
   stim_row_type       directed_rows [$];
   logic [7:0]         group_ops [0:36];
   logic [15:0]        imm_edges [0:4];
   int                 send_idle_pct;
   int                 rsp_idle_pct;
   int                 errors;
   int unsigned        cycles;
   cti_pkg::rsp_type   head_beat;
   logic               beat_ok;

   cpu_transfer_instruction_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---------------------------------------------------------------- executor

   function automatic logic [7:0] reg_read(logic [2:0] idx);
      case (idx)
         cti_pkg::REG_IDX_B: return cpu.b;
         cti_pkg::REG_IDX_C: return cpu.c;
         cti_pkg::REG_IDX_D: return cpu.d;
         cti_pkg::REG_IDX_E: return cpu.e;
         cti_pkg::REG_IDX_H: return cpu.h;
         cti_pkg::REG_IDX_L: return cpu.l;
         cti_pkg::REG_IDX_A: return cpu.a;
         default:            return 8'h00;
      endcase
   endfunction

   function automatic void reg_write(logic [2:0] idx, logic [7:0] v);
      case (idx)
         cti_pkg::REG_IDX_B: cpu.b = v;
         cti_pkg::REG_IDX_C: cpu.c = v;
         cti_pkg::REG_IDX_D: cpu.d = v;
         cti_pkg::REG_IDX_E: cpu.e = v;
         cti_pkg::REG_IDX_H: cpu.h = v;
         cti_pkg::REG_IDX_L: cpu.l = v;
         cti_pkg::REG_IDX_A: cpu.a = v;
         default: ;
      endcase
   endfunction

   function automatic void push_access(logic [1:0] kind, logic [15:0] addr,
                                       logic [7:0] data, logic fin);
      cti_pkg::rsp_type b;
      b = '0;
      b.access_kind = kind;
      b.mem_address = addr;
      b.write_byte  = data;
      b.last        = fin;
      beats_due.push_back(b);
   endfunction

   function automatic void push_retire(logic [4:0] cyc, logic bad);
      cti_pkg::rsp_type b;
      b = '0;
      b.access_kind   = cti_pkg::KIND_RETIRE;
      b.cycle_count   = cyc;
      b.bad_opcode    = bad;
      b.pair_af       = {cpu.a, cpu.f & cti_pkg::FLAGS_MASK};
      b.pair_bc       = {cpu.b, cpu.c};
      b.pair_de       = {cpu.d, cpu.e};
      b.pair_hl       = {cpu.h, cpu.l};
      b.stack_pointer = cpu.sp;
      b.last          = 1'b1;
      beats_due.push_back(b);
   endfunction

   function automatic int store_and_retire(logic [15:0] addr, logic [7:0] data,
                                           logic [4:0] cyc);
      push_access(cti_pkg::KIND_WRITE, addr, data, 1'b0);
      push_retire(cyc, 1'b0);
      return 2;
   endfunction

   function automatic int open_read(logic [7:0] op, logic [15:0] addr);
      cpu.pending_stage  = cti_pkg::STAGE_FIRST;
      cpu.pending_opcode = op;
      push_access(cti_pkg::KIND_READ, addr, 8'h00, 1'b1);
      return 1;
   endfunction

   function automatic void complete_read(logic [7:0] d);
      logic [7:0] op;
      logic [4:0] cyc;
      op = cpu.pending_opcode;
      if ((op & cti_pkg::OP_POP_MASK) == cti_pkg::OP_POP_BASE) begin
         // SP moves on with each reply beat of a pop
         cpu.sp = cpu.sp + 16'd1;
         if (cpu.pending_stage == cti_pkg::STAGE_FIRST) begin
            cpu.popped_low    = d;
            cpu.pending_stage = cti_pkg::STAGE_SECOND;
            push_access(cti_pkg::KIND_READ, cpu.sp, 8'h00, 1'b1);
            return;
         end
         case (op[5:4])
            cti_pkg::PAIR_BC: {cpu.b, cpu.c} = {d, cpu.popped_low};
            cti_pkg::PAIR_DE: {cpu.d, cpu.e} = {d, cpu.popped_low};
            cti_pkg::PAIR_HL: {cpu.h, cpu.l} = {d, cpu.popped_low};
            default: begin
               cpu.a = d;
               cpu.f = cpu.popped_low & cti_pkg::FLAGS_MASK;
            end
         endcase
         cpu.pending_stage = cti_pkg::STAGE_IDLE;
         push_retire(5'd12, 1'b0);
         return;
      end
      if (op[7:6] == 2'b01) reg_write(op[5:3], d);
      else cpu.a = d;
      if (op == cti_pkg::OP_LD_A_HLI) {cpu.h, cpu.l} = {cpu.h, cpu.l} + 16'd1;
      if (op == cti_pkg::OP_LD_A_HLD) {cpu.h, cpu.l} = {cpu.h, cpu.l} - 16'd1;
      cyc = 5'd8;
      if (op == cti_pkg::OP_LDH_A_A8) cyc = 5'd12;
      if (op == cti_pkg::OP_LD_A_A16) cyc = 5'd16;
      cpu.pending_stage = cti_pkg::STAGE_IDLE;
      push_retire(cyc, 1'b0);
   endfunction

   // queues the response beats one request beat causes; returns their number
   function automatic int run_transfer(cti_pkg::req_type r);
      logic [7:0]  op, lo, hi, lw;
      logic [15:0] imm, hl, disp, sum, carries;
      logic [4:0]  cyc;
      op  = r.opcode;
      imm = r.immediate_value;
      lo  = imm[7:0];
      hl  = {cpu.h, cpu.l};
      cyc = 5'd0;
      if (cpu.pending_stage != cti_pkg::STAGE_IDLE) begin
         if (!r.is_reply) return 0;
         complete_read(r.reply_data);
         return 1;
      end
      if (r.is_reply) return 0;
      if (op[7:6] == 2'b01 && op != cti_pkg::OP_HALT) begin
         if (op[2:0] == cti_pkg::REG_IDX_MEM) return open_read(op, hl);
         if (op[5:3] == cti_pkg::REG_IDX_MEM)
            return store_and_retire(hl, reg_read(op[2:0]), 5'd8);
         reg_write(op[5:3], reg_read(op[2:0]));
         push_retire(5'd4, 1'b0);
         return 1;
      end
      case (op)
         cti_pkg::OP_LD_BC_D16: begin {cpu.b, cpu.c} = imm; cyc = 5'd12; end
         cti_pkg::OP_LD_DE_D16: begin {cpu.d, cpu.e} = imm; cyc = 5'd12; end
         cti_pkg::OP_LD_HL_D16: begin {cpu.h, cpu.l} = imm; cyc = 5'd12; end
         cti_pkg::OP_LD_SP_D16: begin cpu.sp = imm; cyc = 5'd12; end
         cti_pkg::OP_LD_B_D8:   begin cpu.b = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_C_D8:   begin cpu.c = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_D_D8:   begin cpu.d = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_E_D8:   begin cpu.e = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_H_D8:   begin cpu.h = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_L_D8:   begin cpu.l = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_A_D8:   begin cpu.a = lo; cyc = 5'd8; end
         cti_pkg::OP_LD_SP_HL:  begin cpu.sp = hl; cyc = 5'd8; end
         cti_pkg::OP_LD_HL_SPR8: begin
            disp    = {{8{lo[7]}}, lo};
            sum     = cpu.sp + disp;
            carries = cpu.sp ^ disp ^ sum;
            cpu.f   = {2'b00, carries[4], carries[8], 4'h0};
            {cpu.h, cpu.l} = sum;
            cyc     = 5'd12;
         end
         cti_pkg::OP_LD_A_BC:  return open_read(op, {cpu.b, cpu.c});
         cti_pkg::OP_LD_A_DE:  return open_read(op, {cpu.d, cpu.e});
         cti_pkg::OP_LD_A_HLI, cti_pkg::OP_LD_A_HLD:
            return open_read(op, hl);
         cti_pkg::OP_LDH_A_C:  return open_read(op, cti_pkg::HIGH_PAGE + cpu.c);
         cti_pkg::OP_LDH_A_A8: return open_read(op, cti_pkg::HIGH_PAGE + lo);
         cti_pkg::OP_LD_A_A16: return open_read(op, imm);
         cti_pkg::OP_POP_BC, cti_pkg::OP_POP_DE, cti_pkg::OP_POP_HL, cti_pkg::OP_POP_AF:
            return open_read(op, cpu.sp);
         cti_pkg::OP_LD_BC_A:  return store_and_retire({cpu.b, cpu.c}, cpu.a, 5'd8);
         cti_pkg::OP_LD_DE_A:  return store_and_retire({cpu.d, cpu.e}, cpu.a, 5'd8);
         cti_pkg::OP_LD_HLI_A: begin
            push_access(cti_pkg::KIND_WRITE, hl, cpu.a, 1'b0);
            {cpu.h, cpu.l} = hl + 16'd1;
            push_retire(5'd8, 1'b0);
            return 2;
         end
         cti_pkg::OP_LD_HLD_A: begin
            push_access(cti_pkg::KIND_WRITE, hl, cpu.a, 1'b0);
            {cpu.h, cpu.l} = hl - 16'd1;
            push_retire(5'd8, 1'b0);
            return 2;
         end
         cti_pkg::OP_LD_HL_D8: return store_and_retire(hl, lo, 5'd12);
         cti_pkg::OP_LDH_C_A:
            return store_and_retire(cti_pkg::HIGH_PAGE + cpu.c, cpu.a, 5'd8);
         cti_pkg::OP_LDH_A8_A:
            return store_and_retire(cti_pkg::HIGH_PAGE + lo, cpu.a, 5'd12);
         cti_pkg::OP_LD_A16_A: return store_and_retire(imm, cpu.a, 5'd16);
         cti_pkg::OP_LD_A16_SP: begin
            push_access(cti_pkg::KIND_WRITE, imm, cpu.sp[7:0], 1'b0);
            push_access(cti_pkg::KIND_WRITE, imm + 16'd1, cpu.sp[15:8], 1'b0);
            push_retire(5'd20, 1'b0);
            return 3;
         end
         cti_pkg::OP_PUSH_BC, cti_pkg::OP_PUSH_DE, cti_pkg::OP_PUSH_HL,
         cti_pkg::OP_PUSH_AF: begin
            case (op[5:4])
               cti_pkg::PAIR_BC: begin hi = cpu.b; lw = cpu.c; end
               cti_pkg::PAIR_DE: begin hi = cpu.d; lw = cpu.e; end
               cti_pkg::PAIR_HL: begin hi = cpu.h; lw = cpu.l; end
               default: begin hi = cpu.a; lw = cpu.f & cti_pkg::FLAGS_MASK; end
            endcase
            // high byte goes to the higher address
            push_access(cti_pkg::KIND_WRITE, cpu.sp - 16'd1, hi, 1'b0);
            push_access(cti_pkg::KIND_WRITE, cpu.sp - 16'd2, lw, 1'b0);
            cpu.sp = cpu.sp - 16'd2;
            push_retire(5'd16, 1'b0);
            return 3;
         end
         default: begin
            push_retire(5'd0, 1'b1);
            return 1;
         end
      endcase
      push_retire(cyc, 1'b0);
      return 1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic cti_pkg::rsp_type typed_retire(logic [4:0] cyc, logic bad,
                                                     logic [15:0] bc);
      cti_pkg::rsp_type b;
      b = '0;
      b.access_kind = cti_pkg::KIND_RETIRE;
      b.cycle_count = cyc;
      b.bad_opcode  = bad;
      b.pair_bc     = bc;
      b.last        = 1'b1;
      return b;
   endfunction

   function automatic void add_row(logic rep, logic [7:0] op, logic [15:0] imm,
                                   logic [7:0] data, bit typed = 1'b0,
                                   cti_pkg::rsp_type want = '0);
      stim_row_type row;
      row.beat.is_reply        = rep;
      row.beat.opcode          = op;
      row.beat.immediate_value = imm;
      row.beat.reply_data      = data;
      row.typed                = typed;
      row.want                 = want;
      directed_rows.push_back(row);
   endfunction

   task automatic send_beat(input cti_pkg::req_type beat, input bit typed,
                            input cti_pkg::rsp_type want, output int made);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      made = run_transfer(beat);
      // a typed row replaces the executor's retire beat with the value read off by hand
      if (typed && made != 0) beats_due[beats_due.size() - 1] = want;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_due.size() != 0);
   endtask

   initial begin
      cti_pkg::req_type beat;
      int               made;
      int               counted;
      int               phase;
      int               pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      cpu           = '0;
      errors        = 0;
      send_idle_pct = 28;
      rsp_idle_pct  = 53;
      counted       = 0;
      phase         = 1;
      group_ops = '{cti_pkg::OP_LD_BC_D16, cti_pkg::OP_LD_DE_D16, cti_pkg::OP_LD_HL_D16,
                    cti_pkg::OP_LD_SP_D16, cti_pkg::OP_LD_B_D8, cti_pkg::OP_LD_C_D8,
                    cti_pkg::OP_LD_D_D8, cti_pkg::OP_LD_E_D8, cti_pkg::OP_LD_H_D8,
                    cti_pkg::OP_LD_L_D8, cti_pkg::OP_LD_A_D8, cti_pkg::OP_LD_SP_HL,
                    cti_pkg::OP_LD_HL_SPR8, cti_pkg::OP_LD_A_BC, cti_pkg::OP_LD_A_DE,
                    cti_pkg::OP_LD_A_HLI, cti_pkg::OP_LD_A_HLD, cti_pkg::OP_LDH_A_C,
                    cti_pkg::OP_LDH_A_A8, cti_pkg::OP_LD_A_A16, cti_pkg::OP_POP_BC,
                    cti_pkg::OP_POP_DE, cti_pkg::OP_POP_HL, cti_pkg::OP_POP_AF,
                    cti_pkg::OP_LD_BC_A, cti_pkg::OP_LD_DE_A, cti_pkg::OP_LD_HLI_A,
                    cti_pkg::OP_LD_HLD_A, cti_pkg::OP_LD_HL_D8, cti_pkg::OP_LDH_C_A,
                    cti_pkg::OP_LDH_A8_A, cti_pkg::OP_LD_A16_A, cti_pkg::OP_LD_A16_SP,
                    cti_pkg::OP_PUSH_BC, cti_pkg::OP_PUSH_DE, cti_pkg::OP_PUSH_HL,
                    cti_pkg::OP_PUSH_AF};
      imm_edges = '{16'h0000, 16'hFFFF, 16'h00FF, 16'h0080, 16'h007F};

      add_row(1'b0, cti_pkg::OP_HALT, 16'h0000, 8'h00, 1'b1,
              typed_retire(5'd0, 1'b1, 16'h0000));
      add_row(1'b1, OP_NOP, 16'hFFFF, 8'hFF);        // reply with nothing outstanding
      add_row(1'b0, cti_pkg::OP_LD_BC_D16, 16'hFFFF, 8'h00, 1'b1,
              typed_retire(5'd12, 1'b0, 16'hFFFF));
      add_row(1'b0, cti_pkg::OP_LD_SP_D16, 16'h0000, 8'h00, 1'b1,
              typed_retire(5'd12, 1'b0, 16'hFFFF));
      add_row(1'b0, cti_pkg::OP_PUSH_BC, 16'h0000, 8'h00);    // SP wraps below zero
      add_row(1'b0, cti_pkg::OP_LD_HL_SPR8, 16'h00FF, 8'h00); // negative offset
      add_row(1'b0, cti_pkg::OP_LD_HL_SPR8, 16'h0001, 8'h00);
      add_row(1'b0, cti_pkg::OP_POP_AF, 16'h0000, 8'h00);
      add_row(1'b0, cti_pkg::OP_LD_A_D8, 16'h0055, 8'h00); // dropped, pop still outstanding
      add_row(1'b1, OP_NOP, 16'h0000, 8'hFF);        // low nibble of F must be masked
      add_row(1'b1, OP_NOP, 16'h0000, 8'h80);
      add_row(1'b0, cti_pkg::OP_LD_HL_D16, 16'hFFFF, 8'h00);
      add_row(1'b0, cti_pkg::OP_LD_A_HLI, 16'h0000, 8'h00);
      add_row(1'b1, OP_NOP, 16'h0000, 8'h5A);        // HL wraps to zero
      add_row(1'b0, cti_pkg::OP_LD_HLD_A, 16'h0000, 8'h00);
      add_row(1'b0, cti_pkg::OP_LD_A16_SP, 16'hFFFF, 8'h00); // second byte wraps to 0x0000
      add_row(1'b0, cti_pkg::OP_LDH_A_A8, 16'h00FF, 8'h00);
      add_row(1'b1, OP_NOP, 16'h0000, 8'h00);
      add_row(1'b0, cti_pkg::OP_LDH_C_A, 16'h0000, 8'h00);
      add_row(1'b0, cti_pkg::OP_LD_A16_A, 16'h0000, 8'h00);
      add_row(1'b0, cti_pkg::OP_LD_A_A16, 16'h8000, 8'h00);
      add_row(1'b1, OP_NOP, 16'h0000, 8'h80);
      add_row(1'b0, cti_pkg::OP_LD_HL_D8, 16'h00A5, 8'h00);
      add_row(1'b0, {2'b01, cti_pkg::REG_IDX_B, cti_pkg::REG_IDX_MEM}, 16'h0000, 8'h00);
      add_row(1'b1, OP_NOP, 16'h0000, 8'h3C);
      add_row(1'b0, {2'b01, cti_pkg::REG_IDX_MEM, cti_pkg::REG_IDX_B}, 16'h0000, 8'h00);
      add_row(1'b0, {2'b01, cti_pkg::REG_IDX_A, cti_pkg::REG_IDX_B}, 16'h0000, 8'h00);
      add_row(1'b0, OP_NOP, 16'h0000, 8'h00);
      add_row(1'b0, OP_RST_38, 16'h0000, 8'h00);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want, made);
      drain_results();

      while (counted < RANDOM_ITEMS) begin
         if (counted == PHASE_LEN && phase == 1) begin
            drain_results();
            phase         = 2;
            send_idle_pct = 53;
            rsp_idle_pct  = 28;
         end else if (counted == 2 * PHASE_LEN && phase == 2) begin
            drain_results();
            phase         = 3;
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         beat.is_reply        = 1'b0;
         beat.opcode          = 8'($urandom);
         beat.immediate_value = ($urandom_range(0, 5) == 0) ?
                                imm_edges[$urandom_range(0, 4)] : 16'($urandom);
         beat.reply_data      = 8'($urandom);
         pick = $urandom_range(0, 99);
         // mostly complete instructions; stray replies and dropped opcodes as noise
         if (cpu.pending_stage != cti_pkg::STAGE_IDLE) beat.is_reply = (pick < 88);
         else if (pick < 6) beat.is_reply = 1'b1;
         else if (pick < 66) beat.opcode = group_ops[$urandom_range(0, 36)];
         else if (pick < 86)
            beat.opcode = {2'b01, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
         send_beat(beat, 1'b0, '0, made);
         counted++;
      end

      req_valid <= 1'b0;
      while (beats_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // ---------------------------------------------------------------- checking

   function automatic logic field_ok(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (beats_due.size() == 0) begin
            $display("%0t: response beat with none due, got %h", $time, rsp_data);
            errors++;
         end else begin
            head_beat = beats_due.pop_front();
            beat_ok = field_ok("access_kind", head_beat.access_kind, rsp_data.access_kind)
                    & field_ok("mem_address", head_beat.mem_address, rsp_data.mem_address)
                    & field_ok("write_byte", head_beat.write_byte, rsp_data.write_byte)
                    & field_ok("cycle_count", head_beat.cycle_count, rsp_data.cycle_count)
                    & field_ok("bad_opcode", head_beat.bad_opcode, rsp_data.bad_opcode)
                    & field_ok("pair_af", head_beat.pair_af, rsp_data.pair_af)
                    & field_ok("pair_bc", head_beat.pair_bc, rsp_data.pair_bc)
                    & field_ok("pair_de", head_beat.pair_de, rsp_data.pair_de)
                    & field_ok("pair_hl", head_beat.pair_hl, rsp_data.pair_hl)
                    & field_ok("stack_pointer", head_beat.stack_pointer,
                               rsp_data.stack_pointer)
                    & field_ok("last", head_beat.last, rsp_data.last);
            if (!beat_ok) errors++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
design/cti_pkg.sv
design/cti_exec.sv
design/cti_rsp_queue.sv
design/cpu_transfer_instruction_unit.sv
bench/tb_cpu_transfer_instruction_unit.sv
